// ===== sv/depth_sort_descending_defines.svh =====
// Assertion macros used by the depth sorter RTL.
`ifndef DEPTH_SORT_DESCENDING_DEFINES_SVH
`define DEPTH_SORT_DESCENDING_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dsd_pkg.sv =====
// Types and constants shared by the depth sorter modules.
`default_nettype none

package dsd_pkg;

  localparam int KEY_BITS  = 32;
  localparam int PORT_TAG_BITS = 16;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic load;  // insert the incoming pair
    logic pop;   // shift toward cell 0 after an output beat
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/dsd_cell.sv =====
// One cell of the insertion chain: holds one (key, tag) pair.
`default_nettype none

module dsd_cell #(
  parameter int TW = 16
) (
  input  wire logic                                 clk,
  input  wire dsd_pkg::cell_ctrl_t                  ctrl,
  input  wire logic signed [dsd_pkg::KEY_BITS-1:0]  in_key,
  input  wire logic [TW-1:0]                        in_tag,
  input  wire logic                                 occ,
  input  wire logic                                 prev_stay,
  input  wire logic signed [dsd_pkg::KEY_BITS-1:0]  prev_key,
  input  wire logic [TW-1:0]                        prev_tag,
  input  wire logic signed [dsd_pkg::KEY_BITS-1:0]  next_key,
  input  wire logic [TW-1:0]                        next_tag,
  output logic                                      stay,
  output logic signed [dsd_pkg::KEY_BITS-1:0]       key,
  output logic [TW-1:0]                             tag
);

  logic signed [dsd_pkg::KEY_BITS-1:0] key_r, key_nxt;
  logic [TW-1:0]                       tag_r, tag_nxt;

  // Hold when this pair is at least as deep as the new one: equal keys keep order.
  assign stay = occ && (key_r >= in_key);

  always_comb begin
    key_nxt = key_r;
    tag_nxt = tag_r;
    if (ctrl.pop) begin
      key_nxt = next_key;
      tag_nxt = next_tag;
    end else if (ctrl.load && !stay) begin
      if (prev_stay) begin
        key_nxt = in_key;
        tag_nxt = in_tag;
      end else begin
        key_nxt = prev_key;
        tag_nxt = prev_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

  assign key = key_r;
  assign tag = tag_r;

endmodule

`default_nettype wire

// ===== sv/depth_sort_descending.sv =====
// Usage: batch depth sorter. Input beats carry (in_seg_tag, in_depth_key,
// in_batch_last) on a valid/ready channel; in_depth_key is signed Q16.16.
// Each accepted beat is placed, if the chain is not full, into a chain of
// MAX_ENTRIES cells kept in descending key order; equal keys keep their
// load order. The beat with in_batch_last is loaded too if there is room,
// then the block drains: it emits every stored pair, deepest first, one
// beat per cycle while out_ready is high on the out_ channel, with out_last
// on the final beat and out_overflowed high on all beats of a batch that
// lost items to a full chain. in_ready is low while draining. The first
// result is visible the cycle after the last input beat. A stall on
// out_ready holds the chain, so the current result stays on the port
// until taken.
// Reset (rst_n low, synchronous) empties the chain and clears the overflow
// mark; stored pairs are not cleared, only the fill count is.
`default_nettype none
`include "depth_sort_descending_defines.svh"

module depth_sort_descending #(
  parameter int MAX_ENTRIES = 64,
  parameter int TAG_BITS    = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [dsd_pkg::PORT_TAG_BITS-1:0]    in_seg_tag,
  input  wire logic signed [dsd_pkg::KEY_BITS-1:0]  in_depth_key,
  input  wire logic                                 in_batch_last,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [dsd_pkg::PORT_TAG_BITS-1:0]         out_tag,
  output logic signed [dsd_pkg::KEY_BITS-1:0]       out_depth,
  output logic                                      out_last,
  output logic                                      out_overflowed
);

  localparam int TW = (TAG_BITS < dsd_pkg::PORT_TAG_BITS) ? TAG_BITS
                                                          : dsd_pkg::PORT_TAG_BITS;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] fill_count_r, fill_count_nxt;
  logic          drop_r, drop_nxt;

  logic in_beat, out_beat, full;
  dsd_pkg::cell_ctrl_t ctrl;

  logic [MAX_ENTRIES-1:0]              stay_w;
  logic signed [dsd_pkg::KEY_BITS-1:0] key_w [MAX_ENTRIES];
  logic [TW-1:0]                       tag_w [MAX_ENTRIES];
  logic [TW-1:0]                       in_tag_w;

  assign in_ready = (state_r == ST_LOAD);
  assign in_beat  = in_valid && in_ready;
  assign out_valid = (state_r == ST_DRAIN);
  assign out_beat = out_valid && out_ready;
  assign full     = (fill_count_r == CW'(MAX_ENTRIES));
  assign in_tag_w = in_seg_tag[TW-1:0];

  assign ctrl.load = in_beat && !full;
  assign ctrl.pop  = out_beat;

  genvar i;
  generate
    for (i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic                                occ;
      logic                                p_stay;
      logic signed [dsd_pkg::KEY_BITS-1:0] p_key, n_key;
      logic [TW-1:0]                       p_tag, n_tag;

      assign occ = (fill_count_r > CW'(i));

      if (i == 0) begin : g_head
        assign p_stay = 1'b1;
        assign p_key  = in_depth_key;
        assign p_tag  = in_tag_w;
      end else begin : g_body
        assign p_stay = stay_w[i-1];
        assign p_key  = key_w[i-1];
        assign p_tag  = tag_w[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_tail
        assign n_key = key_w[i];
        assign n_tag = tag_w[i];
      end else begin : g_mid
        assign n_key = key_w[i+1];
        assign n_tag = tag_w[i+1];
      end

      dsd_cell #(.TW(TW)) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .in_key    (in_depth_key),
        .in_tag    (in_tag_w),
        .occ       (occ),
        .prev_stay (p_stay),
        .prev_key  (p_key),
        .prev_tag  (p_tag),
        .next_key  (n_key),
        .next_tag  (n_tag),
        .stay      (stay_w[i]),
        .key       (key_w[i]),
        .tag       (tag_w[i])
      );
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    fill_count_nxt = fill_count_r;
    drop_nxt       = drop_r;
    if (in_beat) begin
      if (full) begin
        drop_nxt = 1'b1;
      end else begin
        fill_count_nxt = fill_count_r + CW'(1);
      end
      if (in_batch_last) begin
        state_nxt = ST_DRAIN;
      end
    end
    if (out_beat) begin
      fill_count_nxt = fill_count_r - CW'(1);
      if (out_last) begin
        state_nxt = ST_LOAD;
        drop_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      fill_count_r <= '0;
      drop_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_count_r <= fill_count_nxt;
      drop_r       <= drop_nxt;
    end
  end

  assign out_tag        = dsd_pkg::PORT_TAG_BITS'(tag_w[0]);
  assign out_depth      = key_w[0];
  assign out_last       = (fill_count_r == CW'(1));
  assign out_overflowed = drop_r;

  `DSD_ASSERT_NOW(a_fill_range, 1'b1, fill_count_r <= CW'(MAX_ENTRIES), "fill count past capacity")
  `DSD_ASSERT_NOW(a_drain_nonempty, state_r == ST_DRAIN, fill_count_r != '0, "drain with empty chain")
  `DSD_ASSERT_NEXT(a_last_ends, out_valid && out_ready && out_last, state_r == ST_LOAD && fill_count_r == '0 && !drop_r, "batch end did not clear")
  `DSD_ASSERT_NEXT(a_drop_marks, in_valid && in_ready && full, drop_r, "dropped beat not flagged")

endmodule

`default_nettype wire

// ===== tb/sv/depth_sort_descending_tb.sv =====
// Self-checking bench for the batch depth sorter with a stable descending-order scoreboard.
`timescale 1ns / 1ps

module depth_sort_descending_tb;

  localparam int CAPACITY      = 64;
  localparam int TAG_W         = dsd_pkg::PORT_TAG_BITS;
  localparam int KEY_W         = dsd_pkg::KEY_BITS;
  localparam int RANDOM_ITEMS  = 200;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_PCT      = 8;
  localparam int DRAIN_CYCLES  = 2 * CAPACITY + 20;
  localparam int RUN_LIMIT_NS  = 2_000_000;

  typedef struct packed {
    logic [TAG_W-1:0]        tag;
    logic signed [KEY_W-1:0] depth;
    logic                    last;
    logic                    ovf;
  } sorted_beat_t;

  typedef enum {KEYS_ANY, KEYS_TIED, KEYS_EDGE} key_mix_t;

  class sorted_batch_sb;
    logic [TAG_W-1:0]        tag_col[CAPACITY];
    logic signed [KEY_W-1:0] key_col[CAPACITY];
    int                      fill;
    bit                      dropped;
    sorted_beat_t            sorted_q[$];
    int unsigned             error_count;

    function new();
      fill = 0;
      dropped = 1'b0;
      error_count = 0;
    endfunction

    // Insert behind every stored key >= the new one; emit the store on the closing beat.
    function void take_pair(logic [TAG_W-1:0] tag, logic signed [KEY_W-1:0] key,
                            logic last);
      int pos;
      sorted_beat_t b;
      if (fill >= CAPACITY) begin
        dropped = 1'b1;
      end else begin
        pos = fill;
        while (pos > 0 && key_col[pos-1] < key) begin
          key_col[pos] = key_col[pos-1];
          tag_col[pos] = tag_col[pos-1];
          pos--;
        end
        key_col[pos] = key;
        tag_col[pos] = tag;
        fill++;
      end
      if (last) begin
        for (int i = 0; i < fill; i++) begin
          b.tag   = tag_col[i];
          b.depth = key_col[i];
          b.last  = (i == fill - 1);
          b.ovf   = dropped;
          sorted_q.push_back(b);
        end
        fill = 0;
        dropped = 1'b0;
      end
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, field, want, got);
      error_count++;
    endfunction

    function void check_sorted_beat(logic [TAG_W-1:0] tag, logic signed [KEY_W-1:0] depth,
                                    logic last, logic ovf);
      sorted_beat_t want;
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual tag %h depth %h",
                 $time, tag, depth);
        error_count++;
        return;
      end
      want = sorted_q.pop_front();
      if (want.tag !== tag)     report("out_tag", 32'(want.tag), 32'(tag));
      if (want.depth !== depth) report("out_depth", want.depth, depth);
      if (want.last !== last)   report("out_last", 32'(want.last), 32'(last));
      if (want.ovf !== ovf)     report("out_overflowed", 32'(want.ovf), 32'(ovf));
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [TAG_W-1:0]        in_seg_tag = '0;
  logic signed [KEY_W-1:0] in_depth_key = '0;
  logic                    in_batch_last = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [TAG_W-1:0]        out_tag;
  logic signed [KEY_W-1:0] out_depth;
  logic                    out_last;
  logic                    out_overflowed;

  sorted_batch_sb sb = new();
  int unsigned    beats_sent = 0;

  depth_sort_descending #(
    .MAX_ENTRIES(CAPACITY),
    .TAG_BITS(TAG_W)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_seg_tag(in_seg_tag),
    .in_depth_key(in_depth_key),
    .in_batch_last(in_batch_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_tag(out_tag),
    .out_depth(out_depth),
    .out_last(out_last),
    .out_overflowed(out_overflowed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Offer one beat and hold it until the sorter takes it.
  task automatic send_beat(logic [TAG_W-1:0] tag, logic signed [KEY_W-1:0] key,
                           logic last);
    bit calm;
    calm = (beats_sent >= 120 && beats_sent < 200);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_seg_tag    <= tag;
    in_depth_key  <= key;
    in_batch_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_pair(tag, key, last);
    beats_sent++;
  endtask

  function automatic logic signed [KEY_W-1:0] pick_depth(key_mix_t mix);
    logic signed [KEY_W-1:0] k;
    case (mix)
      KEYS_TIED: k = $signed(32'($urandom_range(0, 6))) - 3;
      KEYS_EDGE: begin
        case ($urandom_range(0, 3))
          0:       k = 32'sh7FFF_FFFF;
          1:       k = 32'sh8000_0000;
          2:       k = 32'sh0000_0000;
          default: k = -32'sd1;
        endcase
      end
      default:   k = $signed($urandom);
    endcase
    return k;
  endfunction

  task automatic send_batch(int n, key_mix_t mix);
    for (int i = 0; i < n; i++) begin
      send_beat(TAG_W'($urandom), pick_depth(mix), i == n - 1);
    end
  endtask

  task automatic run_directed();
    // single-beat batches at both key extremes and both tag extremes
    send_beat('1, 32'sh7FFF_FFFF, 1'b1);
    send_beat('0, 32'sh8000_0000, 1'b1);
    // mixed signs, ties on zero and minus one keep load order
    send_beat(16'h0001, 32'sh0000_0000, 1'b0);
    send_beat(16'h0002, -32'sd1, 1'b0);
    send_beat(16'h0003, 32'sh7FFF_FFFF, 1'b0);
    send_beat(16'h0004, 32'sh8000_0000, 1'b0);
    send_beat(16'h0005, 32'sh0001_0000, 1'b0);
    send_beat(16'h0006, -32'sd1, 1'b0);
    send_beat(16'h0007, 32'sh0000_0001, 1'b0);
    send_beat(16'h0008, -32'sd1, 1'b0);
    send_beat(16'h0009, 32'sh0000_0000, 1'b1);
    // ascending input reverses fully
    for (int i = 0; i < 5; i++) begin
      send_beat(16'h0100 + 16'(i), 32'sh0000_8000 * i - 32'sh0001_0000, i == 4);
    end
    // already descending input passes straight through
    for (int i = 0; i < 5; i++) begin
      send_beat(16'hFF00 + 16'(i), 32'sh4000_0000 - 32'sh1000_0000 * i, i == 4);
    end
  endtask

  initial begin : stim
    int       batch_no;
    int       n;
    key_mix_t mix;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    batch_no = 0;
    while (beats_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2:    mix = KEYS_TIED;
        3, 4:       mix = KEYS_EDGE;
        default:    mix = KEYS_ANY;
      endcase
      // exact fill, closing beat dropped when full, several drops in a row
      case (batch_no)
        1:       n = CAPACITY;
        2:       n = CAPACITY + 1;
        3:       n = CAPACITY + 3;
        default: n = $urandom_range(1, 10);
      endcase
      send_batch(n, mix);
      batch_no++;
    end
    in_valid <= 1'b0;
    while (sb.sorted_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned taken;
    int unsigned hold_left;
    bit          held_once;
    taken = 0;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        sb.check_sorted_beat(out_tag, out_depth, out_last, out_overflowed);
        taken++;
      end
      // stall a drain long enough for the sender to back up against in_ready
      if (!held_once && taken >= 100 && out_valid) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (taken >= 150 && taken < 260) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

endmodule
